// ----- design/gn3_pkg.sv -----
// Shared constants, permutation table and helper functions for gradient_noise_3d.
package gn3_pkg;

    localparam int COORD_W    = 24;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = 8;
    localparam int HIDX_W     = IDX_W + 1;
    localparam int FADE_W     = FRAC_BITS + 1;
    localparam int POLY_W     = FRAC_BITS + 5;
    localparam int OFS_W      = FRAC_BITS + 2;
    localparam int GRAD_W     = FRAC_BITS + 3;
    localparam int OUT_W      = 16;
    localparam int NUM_STAGES = 12;
    localparam int CORNERS    = 8;

    localparam logic [POLY_W-1:0] ONE_FX = POLY_W'(1) << FRAC_BITS;

    typedef logic [NUM_STAGES-1:0] stage_en_t;

    localparam logic [7:0] PERM_TABLE [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // Doubled-table view: a 9-bit index wraps onto the 256 entries, so the upper half mirrors the lower
    function automatic logic [IDX_W-1:0] perm(input logic [HIDX_W-1:0] idx);
        return PERM_TABLE[idx[IDX_W-1:0]];
    endfunction

    function automatic logic signed [GRAD_W-1:0] grad(
        input logic [3:0]              h,
        input logic signed [OFS_W-1:0] x,
        input logic signed [OFS_W-1:0] y,
        input logic signed [OFS_W-1:0] z
    );
        logic signed [GRAD_W-1:0] gu;
        logic signed [GRAD_W-1:0] gv;
        gu = (h < 4'd8) ? GRAD_W'(x) : GRAD_W'(y);
        if (h < 4'd4) begin
            gv = GRAD_W'(y);
        end else if (h == 4'd12 || h == 4'd14) begin
            gv = GRAD_W'(x);
        end else begin
            gv = GRAD_W'(z);
        end
        if (h[0]) gu = -gu;
        if (h[1]) gv = -gv;
        return gu + gv;
    endfunction

endpackage

// ----- design/gradient_noise_3d.sv -----
// Top level of gradient_noise_3d: stage control, gradients, blend tree, output map.
//
// Improved 3-D gradient noise of one Q8.16 point per beat, result in unsigned
// Q0.16. Twelve register stages, one beat in and one out per clock while m_ready
// keeps the output moving. Fade polynomial (five stages) runs beside the
// three-stage permutation hash; three two-stage lerp levels follow, then the
// output clamp register. Each stage holds its own valid bit and stalls only
// while full and blocked, so bubbles close up under back-pressure.
module gradient_noise_3d import gn3_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COORD_W-1:0] s_coord_x,
    input  logic [COORD_W-1:0] s_coord_y,
    input  logic [COORD_W-1:0] s_coord_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [OUT_W-1:0]   m_noise_value
);

    stage_en_t vld_reg;
    stage_en_t rdy;
    stage_en_t ld;

    always_comb begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES-2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        ld[0] = s_valid && rdy[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            ld[k] = vld_reg[k-1] && rdy[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= s_valid;
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (rdy[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = vld_reg[NUM_STAGES-1];

    // fade curves, valid at stage 5
    logic [FADE_W-1:0] fu, fv, fw;

    gn3_fade u_fade_x (.aclk(aclk), .en(ld[4:0]), .frac(s_coord_x[FRAC_BITS-1:0]), .fade(fu));
    gn3_fade u_fade_y (.aclk(aclk), .en(ld[4:0]), .frac(s_coord_y[FRAC_BITS-1:0]), .fade(fv));
    gn3_fade u_fade_z (.aclk(aclk), .en(ld[4:0]), .frac(s_coord_z[FRAC_BITS-1:0]), .fade(fw));

    // corner hashes, valid at stage 3
    logic [CORNERS-1:0][3:0] hash;

    gn3_hash u_hash (
        .aclk (aclk),
        .en   (ld[2:0]),
        .ix   (s_coord_x[FRAC_BITS +: IDX_W]),
        .iy   (s_coord_y[FRAC_BITS +: IDX_W]),
        .iz   (s_coord_z[FRAC_BITS +: IDX_W]),
        .hash (hash)
    );

    logic [FRAC_BITS-1:0] tx_reg [3];
    logic [FRAC_BITS-1:0] ty_reg [3];
    logic [FRAC_BITS-1:0] tz_reg [3];

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            tx_reg[0] <= s_coord_x[FRAC_BITS-1:0];
            ty_reg[0] <= s_coord_y[FRAC_BITS-1:0];
            tz_reg[0] <= s_coord_z[FRAC_BITS-1:0];
        end
        for (int k = 1; k < 3; k++) begin
            if (ld[k]) begin
                tx_reg[k] <= tx_reg[k-1];
                ty_reg[k] <= ty_reg[k-1];
                tz_reg[k] <= tz_reg[k-1];
            end
        end
    end

    // corner offsets: p and p-1 per axis
    logic signed [OFS_W-1:0] ox [2];
    logic signed [OFS_W-1:0] oy [2];
    logic signed [OFS_W-1:0] oz [2];

    always_comb begin
        ox[0] = signed'(OFS_W'(tx_reg[2]));
        oy[0] = signed'(OFS_W'(ty_reg[2]));
        oz[0] = signed'(OFS_W'(tz_reg[2]));
        ox[1] = ox[0] - signed'(OFS_W'(ONE_FX));
        oy[1] = oy[0] - signed'(OFS_W'(ONE_FX));
        oz[1] = oz[0] - signed'(OFS_W'(ONE_FX));
    end

    logic signed [GRAD_W-1:0] g4_reg [CORNERS];
    logic signed [GRAD_W-1:0] g5_reg [CORNERS];

    always_ff @(posedge aclk) begin
        for (int c = 0; c < CORNERS; c++) begin
            if (ld[3]) g4_reg[c] <= grad(hash[c], ox[c%2], oy[(c/2)%2], oz[c/4]);
            if (ld[4]) g5_reg[c] <= g4_reg[c];
        end
    end

    // y and z weights wait for their lerp level
    logic [FADE_W-1:0] fv_reg [2];
    logic [FADE_W-1:0] fw_reg [4];

    always_ff @(posedge aclk) begin
        if (ld[5]) begin
            fv_reg[0] <= fv;
            fw_reg[0] <= fw;
        end
        if (ld[6]) begin
            fv_reg[1] <= fv_reg[0];
            fw_reg[1] <= fw_reg[0];
        end
        if (ld[7]) fw_reg[2] <= fw_reg[1];
        if (ld[8]) fw_reg[3] <= fw_reg[2];
    end

    logic signed [GRAD_W-1:0] lx [4];
    logic signed [GRAD_W-1:0] ly [2];
    logic signed [GRAD_W-1:0] lz;

    for (genvar i = 0; i < 4; i++) begin : g_lerp_x
        gn3_lerp u_lerp (
            .aclk (aclk), .en(ld[6:5]), .wgt(fu),
            .a(g5_reg[2*i]), .b(g5_reg[2*i+1]), .y(lx[i])
        );
    end

    for (genvar i = 0; i < 2; i++) begin : g_lerp_y
        gn3_lerp u_lerp (
            .aclk (aclk), .en(ld[8:7]), .wgt(fv_reg[1]),
            .a(lx[2*i]), .b(lx[2*i+1]), .y(ly[i])
        );
    end

    gn3_lerp u_lerp_z (
        .aclk (aclk), .en(ld[10:9]), .wgt(fw_reg[3]),
        .a(ly[0]), .b(ly[1]), .y(lz)
    );

    // (n + 1) / 2 in Q0.16 with clamping
    localparam int VAL_W = GRAD_W + 2;

    logic signed [VAL_W-1:0] val;
    logic [VAL_W-1:0]        half;
    logic [OUT_W-1:0]        out_next;
    logic [OUT_W-1:0]        out_reg;

    always_comb begin
        val = VAL_W'(lz) + signed'(VAL_W'(ONE_FX));
        if (val < 0) begin
            val = '0;
        end else if (val > signed'(VAL_W'(ONE_FX) <<< 2)) begin
            val = signed'(VAL_W'(ONE_FX) <<< 2);
        end
        half = unsigned'(val) >> (FRAC_BITS - 15);
        if (half > VAL_W'(16'hFFFF)) begin
            out_next = 16'hFFFF;
        end else begin
            out_next = OUT_W'(half);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[11]) out_reg <= out_next;
    end

    assign m_noise_value = out_reg;

endmodule

// ----- design/gn3_fade.sv -----
// Five-stage fade curve 6t^5-15t^4+10t^3 for one axis, Horner form.
module gn3_fade import gn3_pkg::*; (
    input  logic                 aclk,
    input  logic [4:0]           en,
    input  logic [FRAC_BITS-1:0] frac,
    output logic [FADE_W-1:0]    fade
);

    logic [FRAC_BITS-1:0]   t_reg [4];
    logic [2*FRAC_BITS-1:0] sq_reg;
    logic [POLY_W-1:0]      p_reg [4];
    logic [POLY_W-1:0]      p_next;
    logic [POLY_W+FRAC_BITS-1:0] m2, m3, m4;
    logic [2*FRAC_BITS+3:0] sq6;

    always_comb begin
        sq6    = (2*FRAC_BITS+4)'(sq_reg) * (2*FRAC_BITS+4)'(6);
        p_next = POLY_W'(sq6 >> FRAC_BITS) + (ONE_FX * POLY_W'(10))
                 - (POLY_W'(t_reg[0]) * POLY_W'(15));
        m2 = (POLY_W+FRAC_BITS)'(p_reg[0]) * (POLY_W+FRAC_BITS)'(t_reg[1]);
        m3 = (POLY_W+FRAC_BITS)'(p_reg[1]) * (POLY_W+FRAC_BITS)'(t_reg[2]);
        m4 = (POLY_W+FRAC_BITS)'(p_reg[2]) * (POLY_W+FRAC_BITS)'(t_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t_reg[0] <= frac;
            sq_reg   <= frac * frac;
        end
        if (en[1]) begin
            t_reg[1] <= t_reg[0];
            p_reg[0] <= p_next;
        end
        if (en[2]) begin
            t_reg[2] <= t_reg[1];
            p_reg[1] <= POLY_W'(m2 >> FRAC_BITS);
        end
        if (en[3]) begin
            t_reg[3] <= t_reg[2];
            p_reg[2] <= POLY_W'(m3 >> FRAC_BITS);
        end
        if (en[4]) begin
            p_reg[3] <= POLY_W'(m4 >> FRAC_BITS);
        end
    end

    assign fade = FADE_W'(p_reg[3]);

endmodule

// ----- design/gn3_hash.sv -----
// Three-stage corner hash through the doubled permutation table.
module gn3_hash import gn3_pkg::*; (
    input  logic                   aclk,
    input  logic [2:0]             en,
    input  logic [IDX_W-1:0]       ix,
    input  logic [IDX_W-1:0]       iy,
    input  logic [IDX_W-1:0]       iz,
    output logic [CORNERS-1:0][3:0] hash
);

    logic [IDX_W-1:0]  r0_reg, r1_reg, iy1_reg, iz1_reg, iz2_reg;
    logic [IDX_W-1:0]  raa_reg, rab_reg, rba_reg, rbb_reg;
    logic [HIDX_W-1:0] a_idx, b_idx, aa, ab, ba, bb;
    logic [IDX_W-1:0]  h_next [CORNERS];
    logic [CORNERS-1:0][3:0] hash_reg;

    always_comb begin
        a_idx = HIDX_W'(r0_reg) + HIDX_W'(iy1_reg);
        b_idx = HIDX_W'(r1_reg) + HIDX_W'(iy1_reg);
        aa    = HIDX_W'(raa_reg) + HIDX_W'(iz2_reg);
        ab    = HIDX_W'(rab_reg) + HIDX_W'(iz2_reg);
        ba    = HIDX_W'(rba_reg) + HIDX_W'(iz2_reg);
        bb    = HIDX_W'(rbb_reg) + HIDX_W'(iz2_reg);
        // corner index is {z, y, x}
        h_next[0] = perm(aa);
        h_next[1] = perm(ba);
        h_next[2] = perm(ab);
        h_next[3] = perm(bb);
        h_next[4] = perm(aa + HIDX_W'(1));
        h_next[5] = perm(ba + HIDX_W'(1));
        h_next[6] = perm(ab + HIDX_W'(1));
        h_next[7] = perm(bb + HIDX_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            r0_reg  <= perm(HIDX_W'(ix));
            r1_reg  <= perm(HIDX_W'(ix) + HIDX_W'(1));
            iy1_reg <= iy;
            iz1_reg <= iz;
        end
        if (en[1]) begin
            raa_reg <= perm(a_idx);
            rab_reg <= perm(a_idx + HIDX_W'(1));
            rba_reg <= perm(b_idx);
            rbb_reg <= perm(b_idx + HIDX_W'(1));
            iz2_reg <= iz1_reg;
        end
        if (en[2]) begin
            for (int c = 0; c < CORNERS; c++) begin
                hash_reg[c] <= h_next[c][3:0];
            end
        end
    end

    assign hash = hash_reg;

endmodule

// ----- design/gn3_lerp.sv -----
// Two-stage lerp a + floor(w*(b-a)/2^F): multiply, then shift and add.
module gn3_lerp import gn3_pkg::*; (
    input  logic                     aclk,
    input  logic [1:0]               en,
    input  logic [FADE_W-1:0]        wgt,
    input  logic signed [GRAD_W-1:0] a,
    input  logic signed [GRAD_W-1:0] b,
    output logic signed [GRAD_W-1:0] y
);

    localparam int PROD_W = FADE_W + GRAD_W + 2;

    logic signed [GRAD_W:0]     diff;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [GRAD_W-1:0]   a_reg;
    logic signed [GRAD_W-1:0]   y_reg;

    assign diff = (GRAD_W+1)'(b) - (GRAD_W+1)'(a);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg <= PROD_W'(signed'({1'b0, wgt})) * PROD_W'(diff);
            a_reg    <= a;
        end
        if (en[1]) begin
            y_reg <= a_reg + GRAD_W'(prod_reg >>> FRAC_BITS);
        end
    end

    assign y = y_reg;

endmodule
